// ===== sv/integer_pixel_upscaler_assert.svh =====
// Assertion macros for the integer pixel upscaler.
// Needs clk and rst_n in the scope of the including module.
`ifndef INTEGER_PIXEL_UPSCALER_ASSERT_SVH
`define INTEGER_PIXEL_UPSCALER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define IPU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define IPU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ipu_pkg.sv =====
// Shared types, constants and helpers for the integer pixel upscaler.
// No dependencies; used by the interfaces, the line buffer and the top level.
package ipu_pkg;

    localparam int COLOR_W    = 8;
    localparam int SCALE_W    = 7;
    localparam int WIDTH_W    = 12;
    localparam int PAD_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam int DEF_MAX_WIDTH = 2048;
    localparam int DEF_MAX_SCALE = 64;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_WIDTH  = 1'b1;

    localparam logic FUNC_PUSH    = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } pixel_t;

    // padding bytes bringing width * scale * 3 bytes to a multiple of 4
    function automatic logic [PAD_W-1:0] row_pad(input logic [1:0] w_lo, input logic [1:0] s_lo);
        logic [3:0] bytes;
        bytes = {2'b00, w_lo} * {2'b00, s_lo};
        bytes = bytes * 4'd3;
        return PAD_W'(4'd0 - bytes);
    endfunction

endpackage

// ===== sv/ipu_stream_if.sv =====
// Valid/ready channel interfaces for the integer pixel upscaler.
// Depends on ipu_pkg for field widths.
interface ipu_pixel_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [ipu_pkg::COLOR_W-1:0] red;
    logic [ipu_pkg::COLOR_W-1:0] green;
    logic [ipu_pkg::COLOR_W-1:0] blue;

    modport source (output valid, output func, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input func, input red, input green, input blue,
                    output ready);
endinterface

interface ipu_result_if;
    logic                        valid;
    logic                        ready;
    logic [ipu_pkg::COLOR_W-1:0] out_red;
    logic [ipu_pkg::COLOR_W-1:0] out_green;
    logic [ipu_pkg::COLOR_W-1:0] out_blue;
    logic                        row_end;
    logic [ipu_pkg::PAD_W-1:0]   pad_bytes;
    logic                        refused;
    logic                        last;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output row_end, output pad_bytes, output refused, output last,
                    input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input row_end, input pad_bytes, input refused, input last,
                    output ready);
endinterface

// ===== sv/ipu_line_buf.sv =====
// Single-row pixel store with one write port and one registered read port.
// Depends on ipu_pkg for the pixel type.
module ipu_line_buf #(
    parameter int DEPTH  = ipu_pkg::DEF_MAX_WIDTH,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  ipu_pkg::pixel_t     wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output ipu_pkg::pixel_t     rd_data
);

    ipu_pkg::pixel_t mem [DEPTH];
    ipu_pkg::pixel_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/integer_pixel_upscaler.sv =====
// Top level of the nearest-neighbour integer upscaler: sequencer, copy counter,
// configuration registers. Depends on ipu_pkg, the stream interfaces and ipu_line_buf.
//
//   channel   direction  handshake       carries
//   pix_in    in         valid/ready     func, red, green, blue
//   res_out   out        valid/ready     out_red..out_blue, row_end, pad_bytes, refused, last
//   cfg       in         cfg_we only     cfg_index, cfg_data
//
// A push goes straight to the copy counter, an advance first through a line buffer read
// state, a refused word is one bare word; the counter emits one word per cycle unless res_out stalls.
// pix_in.ready is low from acceptance until the last result word is taken.
// Output stalls hold the current word and the counter. No clearing pass after reset.
module integer_pixel_upscaler #(
    parameter int MAX_WIDTH = ipu_pkg::DEF_MAX_WIDTH,
    parameter int MAX_SCALE = ipu_pkg::DEF_MAX_SCALE
) (
    input  logic                            clk,
    input  logic                            rst_n,
    ipu_pixel_if.sink                       pix_in,
    ipu_result_if.source                    res_out,
    input  logic                            cfg_we,
    input  logic [ipu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ipu_pkg::CFG_DATA_W-1:0]  cfg_data
);

    `include "integer_pixel_upscaler_assert.svh"

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROWS_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t                         state_reg,     state_next;
    logic [ipu_pkg::SCALE_W-1:0]    scale_reg,     scale_next;
    logic [ipu_pkg::WIDTH_W-1:0]    width_reg,     width_next;
    logic [COL_W-1:0]               col_reg,       col_next;
    logic                           mode_reg,      mode_next;
    logic [ROWS_W-1:0]              rows_reg,      rows_next;
    logic [ROWS_W-1:0]              copies_reg,    copies_next;
    logic                           out_valid_reg, out_valid_next;
    ipu_pkg::pixel_t                pix_reg,       pix_next;
    logic                           row_end_reg,   row_end_next;
    logic [ipu_pkg::PAD_W-1:0]      pad_reg,       pad_next;
    logic                           refused_reg,   refused_next;

    logic [ipu_pkg::SCALE_W-1:0]    scale_eff;
    logic [COL_W-1:0]               last_col;
    logic [1:0]                     width_lo;
    logic                           at_end;
    logic [COL_W-1:0]               col_use;
    logic                           accept;
    logic                           mismatch;
    logic                           mem_we;
    logic                           mem_re;
    ipu_pkg::pixel_t                in_pix;
    ipu_pkg::pixel_t                rd_pix;
    logic                           copy_last;

    always_comb
    begin
        if (scale_reg == '0)
        begin
            scale_eff = ipu_pkg::SCALE_W'(1);
        end
        else if (int'(scale_reg) > MAX_SCALE)
        begin
            scale_eff = ipu_pkg::SCALE_W'(MAX_SCALE);
        end
        else
        begin
            scale_eff = scale_reg;
        end

        if (width_reg == '0)
        begin
            last_col = '0;
            width_lo = 2'd1;
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            last_col = COL_W'(MAX_WIDTH - 1);
            width_lo = 2'(MAX_WIDTH);
        end
        else
        begin
            last_col = COL_W'(width_reg - ipu_pkg::WIDTH_W'(1));
            width_lo = width_reg[1:0];
        end
    end

    assign at_end   = (col_reg >= last_col);
    assign col_use  = at_end ? last_col : col_reg;
    assign accept   = pix_in.valid && pix_in.ready;
    assign mismatch = (pix_in.func != mode_reg);
    assign mem_we   = accept && !mismatch && (pix_in.func == ipu_pkg::FUNC_PUSH);
    assign mem_re   = accept && !mismatch && (pix_in.func == ipu_pkg::FUNC_ADVANCE);
    assign in_pix   = '{red: pix_in.red, green: pix_in.green, blue: pix_in.blue};

    ipu_line_buf #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (col_use),
        .wr_data (in_pix),
        .rd_en   (mem_re),
        .rd_addr (col_use),
        .rd_data (rd_pix)
    );

    always_comb
    begin
        state_next     = state_reg;
        scale_next     = scale_reg;
        width_next     = width_reg;
        col_next       = col_reg;
        mode_next      = mode_reg;
        rows_next      = rows_reg;
        copies_next    = copies_reg;
        out_valid_next = out_valid_reg;
        pix_next       = pix_reg;
        row_end_next   = row_end_reg;
        pad_next       = pad_reg;
        refused_next   = refused_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                ipu_pkg::REG_SCALE_FACTOR: scale_next = cfg_data[ipu_pkg::SCALE_W-1:0];
                ipu_pkg::REG_INPUT_WIDTH:  width_next = cfg_data[ipu_pkg::WIDTH_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mismatch)
                    begin
                        pix_next       = '0;
                        copies_next    = '0;
                        row_end_next   = 1'b0;
                        pad_next       = '0;
                        refused_next   = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = ST_EMIT;
                    end
                    else
                    begin
                        copies_next  = ROWS_W'(scale_eff - ipu_pkg::SCALE_W'(1));
                        row_end_next = at_end;
                        pad_next     = ipu_pkg::row_pad(width_lo, scale_eff[1:0]);
                        refused_next = 1'b0;
                        col_next     = at_end ? '0 : col_reg + COL_W'(1);
                        if (pix_in.func == ipu_pkg::FUNC_PUSH)
                        begin
                            pix_next       = in_pix;
                            out_valid_next = 1'b1;
                            state_next     = ST_EMIT;
                            if (at_end && scale_eff > ipu_pkg::SCALE_W'(1))
                            begin
                                mode_next = 1'b1;
                                rows_next = ROWS_W'(scale_eff - ipu_pkg::SCALE_W'(1));
                            end
                        end
                        else
                        begin
                            state_next = ST_READ;
                            if (at_end)
                            begin
                                if (rows_reg <= ROWS_W'(1))
                                begin
                                    rows_next = '0;
                                    mode_next = 1'b0;
                                end
                                else
                                begin
                                    rows_next = rows_reg - ROWS_W'(1);
                                end
                            end
                        end
                    end
                end
            end
            ST_READ:
            begin
                pix_next       = rd_pix;
                out_valid_next = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (res_out.ready)
                begin
                    if (copy_last)
                    begin
                        out_valid_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        copies_next = copies_reg - ROWS_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scale_reg     <= ipu_pkg::SCALE_W'(1);
            width_reg     <= ipu_pkg::WIDTH_W'(1);
            col_reg       <= '0;
            mode_reg      <= 1'b0;
            rows_reg      <= '0;
            copies_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scale_reg     <= scale_next;
            width_reg     <= width_next;
            col_reg       <= col_next;
            mode_reg      <= mode_next;
            rows_reg      <= rows_next;
            copies_reg    <= copies_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg     <= pix_next;
        row_end_reg <= row_end_next;
        pad_reg     <= pad_next;
        refused_reg <= refused_next;
    end

    assign copy_last         = (copies_reg == '0);
    assign pix_in.ready      = (state_reg == ST_IDLE);
    assign res_out.valid     = out_valid_reg;
    assign res_out.out_red   = pix_reg.red;
    assign res_out.out_green = pix_reg.green;
    assign res_out.out_blue  = pix_reg.blue;
    assign res_out.row_end   = row_end_reg && copy_last;
    assign res_out.pad_bytes = (row_end_reg && copy_last) ? pad_reg : '0;
    assign res_out.refused   = refused_reg;
    assign res_out.last      = copy_last;

    `IPU_ASSERT_NOW(a_busy_while_out, res_out.valid, !pix_in.ready, "input ready while a word is pending")
    `IPU_ASSERT_NEXT(a_accept_blocks, accept, !pix_in.ready, "input ready right after acceptance")
    `IPU_ASSERT_NOW(a_mode_rows, 1'b1, mode_reg == (rows_reg != '0), "replay mode and row count disagree")
    `IPU_ASSERT_NOW(a_refused_word, res_out.valid && res_out.refused, res_out.last && !res_out.row_end && pix_reg == '0, "refused word not a bare final word")

endmodule

// ===== tb/tb_integer_pixel_upscaler.sv =====
// Self-checking testbench for the nearest-neighbour integer upscaler: directed rows,
// register edge cases, back-pressure and a long random stream, scored word by word.
// Depends on ipu_pkg, the ipu stream interfaces and integer_pixel_upscaler.
module tb_integer_pixel_upscaler;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ipu_pkg::COLOR_W-1:0] red;
        logic [ipu_pkg::COLOR_W-1:0] green;
        logic [ipu_pkg::COLOR_W-1:0] blue;
        logic                        row_end;
        logic [ipu_pkg::PAD_W-1:0]   pad_bytes;
        logic                        refused;
        logic                        last;
    } upscaled_word_t;

    typedef logic [ipu_pkg::CFG_IDX_W-1:0]  cfg_index_t;
    typedef logic [ipu_pkg::CFG_DATA_W-1:0] cfg_data_t;

    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 70;
    localparam int HOLD_CYCLES   = 300;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_data;

    ipu_pixel_if  pix_if();
    ipu_result_if res_if();

    integer_pixel_upscaler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_if),
        .res_out   (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // upscaler state as predicted
    ipu_pkg::pixel_t             line_copy [ipu_pkg::DEF_MAX_WIDTH];
    int                          next_col;
    int                          rows_to_replay;
    logic                        replaying;
    logic [ipu_pkg::SCALE_W-1:0] scale_reg;
    logic [ipu_pkg::WIDTH_W-1:0] width_reg;
    int                          filled_cols;

    upscaled_word_t pending_words [$];
    int             fault_count;
    int             idle_pct;
    int             hold_req;
    int             quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int eff_scale(input logic [ipu_pkg::SCALE_W-1:0] s);
        if (s == 0)
            return 1;
        return (s > ipu_pkg::DEF_MAX_SCALE) ? ipu_pkg::DEF_MAX_SCALE : int'(s);
    endfunction

    function automatic int eff_width(input logic [ipu_pkg::WIDTH_W-1:0] w);
        if (w == 0)
            return 1;
        return (w > ipu_pkg::DEF_MAX_WIDTH) ? ipu_pkg::DEF_MAX_WIDTH : int'(w);
    endfunction

    function automatic int gap_len();
        if ($urandom_range(99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic ipu_pkg::pixel_t rand_pixel();
        logic [23:0] bits;
        bits = 24'($urandom_range(24'hFFFFFF));
        return bits;
    endfunction

    task automatic predict_upscale(input logic func, input ipu_pkg::pixel_t px);
        int              sc;
        int              wd;
        int              col;
        int              pad;
        logic            at_end;
        ipu_pkg::pixel_t src;
        upscaled_word_t  w;
        sc = eff_scale(scale_reg);
        wd = eff_width(width_reg);
        w = '0;
        if (func != replaying)
        begin
            w.refused = 1'b1;
            w.last = 1'b1;
            pending_words.push_back(w);
            return;
        end
        col = next_col;
        at_end = (col >= wd - 1);
        if (at_end)
            col = wd - 1;
        pad = (4 - ((wd * sc * 3) & 3)) & 3;
        if (func == ipu_pkg::FUNC_PUSH)
        begin
            line_copy[col] = px;
            if (col + 1 > filled_cols)
                filled_cols = col + 1;
            src = px;
        end
        else
            src = line_copy[col];
        for (int k = 0; k < sc; k++)
        begin
            w.red = src.red;
            w.green = src.green;
            w.blue = src.blue;
            w.last = (k == sc - 1);
            w.row_end = w.last && at_end;
            w.pad_bytes = w.row_end ? ipu_pkg::PAD_W'(pad) : '0;
            w.refused = 1'b0;
            pending_words.push_back(w);
        end
        if (!at_end)
            next_col = col + 1;
        else
        begin
            next_col = 0;
            if (func == ipu_pkg::FUNC_PUSH)
            begin
                if (sc > 1)
                begin
                    replaying = 1'b1;
                    rows_to_replay = (sc - 1) & 63;
                end
            end
            else if (rows_to_replay <= 1)
            begin
                rows_to_replay = 0;
                replaying = 1'b0;
            end
            else
                rows_to_replay--;
        end
    endtask

    task automatic offer_pixel(input logic func, input ipu_pkg::pixel_t px);
        int gap;
        gap = 0;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            gap = gap_len();
        if (gap > 0)
        begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.func <= func;
        pix_if.red <= px.red;
        pix_if.green <= px.green;
        pix_if.blue <= px.blue;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
        predict_upscale(func, px);
    endtask

    task automatic offer_stream_item();
        logic func;
        func = replaying ? ipu_pkg::FUNC_ADVANCE : ipu_pkg::FUNC_PUSH;
        if ($urandom_range(99) < 8)
            func = ~func;
        offer_pixel(func, rand_pixel());
    endtask

    task automatic wait_drained();
        pix_if.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input cfg_data_t value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        // never let a replay reach a column that was never stored
        if (idx == ipu_pkg::REG_INPUT_WIDTH && replaying
            && eff_width(value) > filled_cols)
            value = cfg_data_t'(filled_cols);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == ipu_pkg::REG_SCALE_FACTOR)
            scale_reg = value[ipu_pkg::SCALE_W-1:0];
        else
            width_reg = value[ipu_pkg::WIDTH_W-1:0];
    endtask

    task automatic test_reset_state();
        offer_pixel(ipu_pkg::FUNC_PUSH, 24'hFFFFFF);
        offer_pixel(ipu_pkg::FUNC_PUSH, 24'h000000);
        offer_pixel(ipu_pkg::FUNC_ADVANCE, 24'h5A5A5A);
        write_reg(ipu_pkg::REG_SCALE_FACTOR, '0);
        write_reg(ipu_pkg::REG_INPUT_WIDTH, '0);
        offer_pixel(ipu_pkg::FUNC_PUSH, 24'hA5C33C);
        offer_pixel(ipu_pkg::FUNC_ADVANCE, 24'hFFFFFF);
    endtask

    task automatic test_row_replay();
        write_reg(ipu_pkg::REG_SCALE_FACTOR, 3);
        write_reg(ipu_pkg::REG_INPUT_WIDTH, 2);
        offer_pixel(ipu_pkg::FUNC_PUSH, 24'hFF0000);
        offer_pixel(ipu_pkg::FUNC_PUSH, 24'h00FF00);
        offer_pixel(ipu_pkg::FUNC_PUSH, 24'h0000FF);
        repeat (4) offer_pixel(ipu_pkg::FUNC_ADVANCE, rand_pixel());
        offer_pixel(ipu_pkg::FUNC_ADVANCE, 24'h123456);
    endtask

    task automatic test_midrow_registers();
        write_reg(ipu_pkg::REG_SCALE_FACTOR, 1);
        write_reg(ipu_pkg::REG_INPUT_WIDTH, 12'hFFF);
        offer_pixel(ipu_pkg::FUNC_PUSH, 24'h010203);
        offer_pixel(ipu_pkg::FUNC_PUSH, 24'hFEFDFC);
        write_reg(ipu_pkg::REG_INPUT_WIDTH, 2);
        offer_pixel(ipu_pkg::FUNC_PUSH, 24'h808080);
        write_reg(ipu_pkg::REG_INPUT_WIDTH, 3);
        write_reg(ipu_pkg::REG_SCALE_FACTOR, 2);
        offer_pixel(ipu_pkg::FUNC_PUSH, 24'h7F7F7F);
        write_reg(ipu_pkg::REG_SCALE_FACTOR, 3);
        offer_pixel(ipu_pkg::FUNC_PUSH, 24'h00FFFF);
        offer_pixel(ipu_pkg::FUNC_PUSH, 24'hFFFF00);
        write_reg(ipu_pkg::REG_SCALE_FACTOR, 2);
        repeat (6) offer_pixel(ipu_pkg::FUNC_ADVANCE, rand_pixel());
    endtask

    task automatic test_scale_ceiling();
        write_reg(ipu_pkg::REG_INPUT_WIDTH, 1);
        write_reg(ipu_pkg::REG_SCALE_FACTOR, 127);
        offer_pixel(ipu_pkg::FUNC_PUSH, rand_pixel());
        repeat (63) offer_pixel(ipu_pkg::FUNC_ADVANCE, rand_pixel());
    endtask

    task automatic test_backpressure();
        idle_pct = 0;
        write_reg(ipu_pkg::REG_SCALE_FACTOR, 5);
        write_reg(ipu_pkg::REG_INPUT_WIDTH, 3);
        hold_req = HOLD_CYCLES;
        repeat (3) offer_pixel(ipu_pkg::FUNC_PUSH, rand_pixel());
        repeat (4) offer_pixel(ipu_pkg::FUNC_ADVANCE, rand_pixel());
        wait_drained();
        repeat (8) offer_pixel(ipu_pkg::FUNC_ADVANCE, rand_pixel());
    endtask

    task automatic test_random_stream(input int item_budget);
        int sent;
        int seg;
        int pick;
        sent = 0;
        while (sent < item_budget)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                write_reg(ipu_pkg::REG_SCALE_FACTOR, cfg_data_t'($urandom_range(1, 4)));
            else if (pick < 88)
                write_reg(ipu_pkg::REG_SCALE_FACTOR, cfg_data_t'($urandom_range(5, 12)));
            else if (pick < 93)
                write_reg(ipu_pkg::REG_SCALE_FACTOR, cfg_data_t'($urandom_range(13, 64)));
            else if (pick < 96)
                write_reg(ipu_pkg::REG_SCALE_FACTOR, 0);
            else
                write_reg(ipu_pkg::REG_SCALE_FACTOR, cfg_data_t'($urandom_range(65, 127)));
            pick = $urandom_range(99);
            if (pick < 75)
                write_reg(ipu_pkg::REG_INPUT_WIDTH, cfg_data_t'($urandom_range(1, 6)));
            else if (pick < 92)
                write_reg(ipu_pkg::REG_INPUT_WIDTH, cfg_data_t'($urandom_range(7, 24)));
            else if (pick < 96)
                write_reg(ipu_pkg::REG_INPUT_WIDTH, 0);
            else
                write_reg(ipu_pkg::REG_INPUT_WIDTH, cfg_data_t'($urandom_range(25, 4095)));
            pick = $urandom_range(2);
            idle_pct = (pick == 0) ? 0 : ((pick == 1) ? 20 : 50);
            seg = $urandom_range(5, 30);
            repeat (seg) offer_stream_item();
            sent += seg;
        end
    endtask

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        upscaled_word_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("result word with no prediction pending");
                fault_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                compare_field("out_red", want.red, res_if.out_red);
                compare_field("out_green", want.green, res_if.out_green);
                compare_field("out_blue", want.blue, res_if.out_blue);
                compare_field("row_end", 8'(want.row_end), 8'(res_if.row_end));
                compare_field("pad_bytes", 8'(want.pad_bytes), 8'(res_if.pad_bytes));
                compare_field("refused", 8'(want.refused), 8'(res_if.refused));
                compare_field("last", 8'(want.last), 8'(res_if.last));
            end
        end
    end

    initial
    begin
        int n;
        res_if.ready = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req > 0)
            begin
                res_if.ready <= 1'b0;
                n = hold_req;
                hold_req = 0;
                repeat (n) @(posedge clk);
            end
            else if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            begin
                res_if.ready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
            else
            begin
                res_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pix_if.valid = 1'b0;
        pix_if.func = ipu_pkg::FUNC_PUSH;
        pix_if.red = '0;
        pix_if.green = '0;
        pix_if.blue = '0;
        fault_count = 0;
        hold_req = 0;
        idle_pct = 25;
        next_col = 0;
        rows_to_replay = 0;
        replaying = 1'b0;
        scale_reg = 1;
        width_reg = 1;
        filled_cols = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_row_replay();
        test_midrow_registers();
        idle_pct = 30;
        test_scale_ceiling();
        test_backpressure();
        test_random_stream(260);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
